@@ rtl/hpid_pkg.sv @@
// ----------------------------------------------------------------------------
// Heading PID package
// Widths, register map and reset values shared by the heading PID block.
// ----------------------------------------------------------------------------
package hpid_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int SUM_WIDTH      = 32;
    localparam int HEADING_WIDTH  = 16;

    localparam int GAIN_WIDTH  = 16;
    localparam int SPEED_WIDTH = 7;
    localparam int BAND_WIDTH  = 8;
    localparam int TICKS_WIDTH = 4;
    localparam int DRIVE_WIDTH = 5;
    localparam int LIMIT_WIDTH = 4;

    localparam int ERR_WIDTH   = HEADING_WIDTH + 1;
    localparam int DIFF_WIDTH  = ERR_WIDTH + 1;
    localparam int PE_WIDTH    = GAIN_WIDTH + 1 + ERR_WIDTH;
    localparam int PI_WIDTH    = GAIN_WIDTH + 1 + SUM_WIDTH;
    localparam int PD_WIDTH    = GAIN_WIDTH + 1 + DIFF_WIDTH;
    localparam int ACC_WIDTH   = PI_WIDTH + 2;

    localparam int IN_BYTES    = (HEADING_WIDTH + 7) / 8;
    localparam int OUT_BYTES   = (DRIVE_WIDTH + 7) / 8;

    localparam int ADDR_WIDTH  = 5;
    localparam int DATA_WIDTH  = 32;

    localparam logic [2:0] REG_GAIN_P         = 3'd0;
    localparam logic [2:0] REG_GAIN_I         = 3'd1;
    localparam logic [2:0] REG_GAIN_D         = 3'd2;
    localparam logic [2:0] REG_SPEED_PCT      = 3'd3;
    localparam logic [2:0] REG_TARGET_HEADING = 3'd4;
    localparam logic [2:0] REG_SETTLE_BAND    = 3'd5;
    localparam logic [2:0] REG_SETTLE_TICKS   = 3'd6;

    localparam logic [GAIN_WIDTH-1:0]    GAIN_P_RST       = 16'd256;
    localparam logic [GAIN_WIDTH-1:0]    GAIN_I_RST       = 16'd0;
    localparam logic [GAIN_WIDTH-1:0]    GAIN_D_RST       = 16'd2125;
    localparam logic [SPEED_WIDTH-1:0]   SPEED_PCT_RST    = 7'd100;
    localparam logic [HEADING_WIDTH-1:0] TARGET_RST       = '0;
    localparam logic [BAND_WIDTH-1:0]    SETTLE_BAND_RST  = 8'd4;
    localparam logic [TICKS_WIDTH-1:0]   SETTLE_TICKS_RST = 4'd7;

    localparam logic [SPEED_WIDTH-1:0]   SPEED_FULL = 7'd100;

endpackage

@@ rtl/heading_pid_with_clamp_and_settle.sv @@
// ----------------------------------------------------------------------------
// Heading PID with output clamp and settle detection
// Turns heading samples into a clamped drive voltage and a settled flag.
// ----------------------------------------------------------------------------
// Each heading word enters on the s_ channel; each one yields exactly one
// result word on the m_ channel, in order. Gains, speed cap, target heading
// and settle criteria are written over the APB port, by the user only while
// the block is idle; the block does not enforce this. The first stage forms
// the error and updates the saturating integral, the previous error and the
// in-band counter as the word is accepted. The second stage forms the three
// gain products; the third sums them, scales, clamps and registers the
// result. The feedback state updates as each word is accepted, so a new word
// is accepted in every cycle while m_tready is high. Each stage holds its
// word while the next one is full, so the block keeps accepting until all
// three stages hold words while m_tready stays low.
// Reset clears the integral, previous error, counter and all stage valids,
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module heading_pid_with_clamp_and_settle (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] heading_deg
    input  logic [8*hpid_pkg::IN_BYTES-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [4:0] drive_volts, upper bits zero
    output logic [8*hpid_pkg::OUT_BYTES-1:0]       m_tdata,
    // [0] settled
    output logic                                   m_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [hpid_pkg::ADDR_WIDTH-1:0]        paddr,
    input  logic [hpid_pkg::DATA_WIDTH-1:0]        pwdata,
    output logic [hpid_pkg::DATA_WIDTH-1:0]        prdata,
    output logic                                   pready
);

    localparam int HW  = hpid_pkg::HEADING_WIDTH;
    localparam int EW  = hpid_pkg::ERR_WIDTH;
    localparam int DW  = hpid_pkg::DIFF_WIDTH;
    localparam int SW  = hpid_pkg::SUM_WIDTH;
    localparam int GW  = hpid_pkg::GAIN_WIDTH;
    localparam int AW  = hpid_pkg::ACC_WIDTH;
    localparam int FB  = hpid_pkg::GAIN_FRAC_BITS;
    localparam int TW  = hpid_pkg::TICKS_WIDTH;
    localparam int BW  = hpid_pkg::BAND_WIDTH;
    localparam int LW  = hpid_pkg::LIMIT_WIDTH;
    localparam int VW  = hpid_pkg::DRIVE_WIDTH;
    localparam int PW  = hpid_pkg::SPEED_WIDTH;
    localparam int DAT = hpid_pkg::DATA_WIDTH;

    // Configuration registers.
    logic [GW-1:0] gain_p_reg;
    logic [GW-1:0] gain_i_reg;
    logic [GW-1:0] gain_d_reg;
    logic [PW-1:0] speed_pct_reg;
    logic [HW-1:0] target_reg;
    logic [BW-1:0] band_reg;
    logic [TW-1:0] ticks_reg;

    logic          cfg_write;
    logic [2:0]    cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[hpid_pkg::ADDR_WIDTH-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= hpid_pkg::GAIN_P_RST;
            gain_i_reg    <= hpid_pkg::GAIN_I_RST;
            gain_d_reg    <= hpid_pkg::GAIN_D_RST;
            speed_pct_reg <= hpid_pkg::SPEED_PCT_RST;
            target_reg    <= hpid_pkg::TARGET_RST;
            band_reg      <= hpid_pkg::SETTLE_BAND_RST;
            ticks_reg     <= hpid_pkg::SETTLE_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hpid_pkg::REG_GAIN_P:         gain_p_reg    <= pwdata[GW-1:0];
                hpid_pkg::REG_GAIN_I:         gain_i_reg    <= pwdata[GW-1:0];
                hpid_pkg::REG_GAIN_D:         gain_d_reg    <= pwdata[GW-1:0];
                hpid_pkg::REG_SPEED_PCT:      speed_pct_reg <= pwdata[PW-1:0];
                hpid_pkg::REG_TARGET_HEADING: target_reg    <= pwdata[HW-1:0];
                hpid_pkg::REG_SETTLE_BAND:    band_reg      <= pwdata[BW-1:0];
                hpid_pkg::REG_SETTLE_TICKS:   ticks_reg     <= pwdata[TW-1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            hpid_pkg::REG_GAIN_P:         prdata = DAT'(gain_p_reg);
            hpid_pkg::REG_GAIN_I:         prdata = DAT'(gain_i_reg);
            hpid_pkg::REG_GAIN_D:         prdata = DAT'(gain_d_reg);
            hpid_pkg::REG_SPEED_PCT:      prdata = DAT'(speed_pct_reg);
            hpid_pkg::REG_TARGET_HEADING: prdata = DAT'(target_reg);
            hpid_pkg::REG_SETTLE_BAND:    prdata = DAT'(band_reg);
            hpid_pkg::REG_SETTLE_TICKS:   prdata = DAT'(ticks_reg);
            default:                      prdata = '0;
        endcase
    end

    // Stage handshake.
    logic valid_a_reg, valid_b_reg, valid_c_reg;
    logic ready_a, ready_b, ready_c;
    logic s_accept;

    assign ready_c  = !valid_c_reg || m_tready;
    assign ready_b  = !valid_b_reg || ready_c;
    assign ready_a  = !valid_a_reg || ready_b;
    assign s_tready = ready_a;
    assign s_accept = s_tvalid && ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= s_tvalid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
            if (ready_c)
            begin
                valid_c_reg <= valid_b_reg;
            end
        end
    end

    // Feedback state and error stage.
    logic signed [SW-1:0] error_sum_reg, error_sum_next;
    logic signed [EW-1:0] last_error_reg, last_error_next;
    logic [TW-1:0]        count_reg, count_next;

    logic signed [EW-1:0] err;
    logic signed [SW:0]   sum_wide;
    logic signed [SW-1:0] sum_sat;
    logic signed [DW-1:0] diff;
    logic [EW-1:0]        err_mag;
    logic                 in_band;
    logic [TW-1:0]        count_inc;
    logic                 settle;

    assign err      = {target_reg[HW-1], target_reg} - {s_tdata[HW-1], s_tdata[HW-1:0]};
    assign sum_wide = {error_sum_reg[SW-1], error_sum_reg} + {{(SW+1-EW){err[EW-1]}}, err};
    assign diff     = {err[EW-1], err} - {last_error_reg[EW-1], last_error_reg};
    assign err_mag  = err[EW-1] ? EW'(-err) : EW'(err);
    assign in_band  = err_mag <= {{(EW-BW){1'b0}}, band_reg};
    assign count_inc = count_reg + 1'b1;
    assign settle   = in_band && (count_inc >= ticks_reg);

    always_comb
    begin
        if (sum_wide[SW] != sum_wide[SW-1])
        begin
            sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SW-1:0];
        end

        if (settle)
        begin
            error_sum_next  = '0;
            last_error_next = '0;
            count_next      = '0;
        end
        else
        begin
            error_sum_next  = sum_sat;
            last_error_next = err;
            count_next      = in_band ? count_inc : '0;
        end
    end

    logic signed [EW-1:0] err_a_reg;
    logic signed [SW-1:0] sum_a_reg;
    logic signed [DW-1:0] diff_a_reg;
    logic                 settle_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            count_reg      <= '0;
        end
        else if (s_accept)
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            err_a_reg    <= err;
            sum_a_reg    <= sum_sat;
            diff_a_reg   <= diff;
            settle_a_reg <= settle;
        end
    end

    // Product stage.
    logic signed [hpid_pkg::PE_WIDTH-1:0] prod_p, prod_p_reg;
    logic signed [hpid_pkg::PI_WIDTH-1:0] prod_i, prod_i_reg;
    logic signed [hpid_pkg::PD_WIDTH-1:0] prod_d, prod_d_reg;
    logic                                 err_pos_b_reg, err_neg_b_reg, settle_b_reg;

    assign prod_p = $signed({1'b0, gain_p_reg}) * err_a_reg;
    assign prod_i = $signed({1'b0, gain_i_reg}) * sum_a_reg;
    assign prod_d = $signed({1'b0, gain_d_reg}) * diff_a_reg;

    always_ff @(posedge clk)
    begin
        if (ready_b && valid_a_reg)
        begin
            prod_p_reg    <= prod_p;
            prod_i_reg    <= prod_i;
            prod_d_reg    <= prod_d;
            err_pos_b_reg <= !err_a_reg[EW-1] && (err_a_reg != '0);
            err_neg_b_reg <= err_a_reg[EW-1];
            settle_b_reg  <= settle_a_reg;
        end
    end

    // Sum, scale and clamp stage.
    logic signed [AW-1:0] acc;
    logic [AW-1:0]        acc_mag;
    logic [AW-1:0]        acc_shift;
    logic                 too_big;
    logic [LW-1:0]        mag_low;
    logic [PW-1:0]        speed_cl;
    logic [13:0]          limit_prod;
    logic [LW-1:0]        limit;
    logic                 clamp;
    logic [VW-1:0]        drive;
    logic [VW-1:0]        drive_reg;
    logic                 settled_reg;

    assign acc       = prod_p_reg + prod_i_reg + prod_d_reg;
    assign acc_mag   = acc[AW-1] ? AW'(-acc) : AW'(acc);
    assign acc_shift = acc_mag >> FB;
    assign too_big   = |acc_shift[AW-1:LW];
    assign mag_low   = acc_shift[LW-1:0];

    // Volts = floor(speed * 12 / 100) = floor(speed * 3 / 25), exact for speed <= 100.
    assign speed_cl   = (speed_pct_reg > hpid_pkg::SPEED_FULL) ? hpid_pkg::SPEED_FULL
                                                               : speed_pct_reg;
    assign limit_prod = 14'(speed_cl) * 14'd123;
    assign limit      = limit_prod[13:10];
    assign clamp      = too_big || (mag_low >= limit);

    always_comb
    begin
        if (settle_b_reg)
        begin
            drive = '0;
        end
        else if (clamp)
        begin
            if (err_pos_b_reg)
            begin
                drive = {1'b0, limit};
            end
            else if (err_neg_b_reg)
            begin
                drive = VW'(-{1'b0, limit});
            end
            else
            begin
                drive = '0;
            end
        end
        else
        begin
            drive = acc[AW-1] ? VW'(-{1'b0, mag_low}) : {1'b0, mag_low};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_c && valid_b_reg)
        begin
            drive_reg   <= drive;
            settled_reg <= settle_b_reg;
        end
    end

    assign m_tvalid = valid_c_reg;
    assign m_tdata  = {{(8*hpid_pkg::OUT_BYTES-VW){1'b0}}, drive_reg};
    assign m_tuser  = settled_reg;

endmodule

@@ rtl/hpid_checker.sv @@
// ----------------------------------------------------------------------------
// Heading PID port checker
// Watches the result channel of the heading PID block.
// ----------------------------------------------------------------------------
module hpid_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [8*hpid_pkg::OUT_BYTES-1:0]  m_tdata,
    input logic                              m_tuser
);

    localparam int VW = hpid_pkg::DRIVE_WIDTH;

    // A settled word always commands a brake.
    a_settled_brakes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[VW-1:0] == '0)
        else $error("settled word carries nonzero drive");

    // The drive never exceeds twelve volts either way.
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[VW-1] && m_tdata[VW-2:0] <= 4'd12) ||
                     (m_tdata[VW-1] && m_tdata[VW-2:0] >= 4'd4))
        else $error("drive outside the volt range");

    // The padding above the drive field stays zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> VW) == '0)
        else $error("result padding is not zero");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

endmodule

bind heading_pid_with_clamp_and_settle hpid_checker u_hpid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Heading PID block testbench
// Streams heading words into the block and checks every drive and settled
// word against an in-bench copy of the controller. Gains, speed cap, target
// and settle criteria change over the APB port between idle phases. The run
// includes directed edge words, two short integral windup runs and random
// heading moves that mostly converge onto the target.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PIPE_LATENCY = 3;
    localparam int VOLT_FULL = 12;
    localparam int HEAD_MAX = (1 << (hpid_pkg::HEADING_WIDTH - 1)) - 1;
    localparam int HEAD_MIN = -(1 << (hpid_pkg::HEADING_WIDTH - 1));
    localparam int WINDUP_WORDS = 20;
    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam longint SUM_MAX = (longint'(1) << (hpid_pkg::SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct packed {
        logic                             settled;
        logic [hpid_pkg::DRIVE_WIDTH-1:0] drive;
    } drive_word_t;

    logic                                       clk = 1'b0;
    logic                                       rst_n = 1'b0;
    logic                                       s_tvalid = 1'b0;
    logic                                       s_tready;
    logic [8*hpid_pkg::IN_BYTES-1:0]            s_tdata = '0;
    logic                                       m_tvalid;
    logic                                       m_tready = 1'b0;
    logic [8*hpid_pkg::OUT_BYTES-1:0]           m_tdata;
    logic                                       m_tuser;
    logic                                       psel = 1'b0;
    logic                                       penable = 1'b0;
    logic                                       pwrite = 1'b0;
    logic [hpid_pkg::ADDR_WIDTH-1:0]            paddr = '0;
    logic [hpid_pkg::DATA_WIDTH-1:0]            pwdata = '0;
    logic [hpid_pkg::DATA_WIDTH-1:0]            prdata;
    logic                                       pready;

    logic [hpid_pkg::GAIN_WIDTH-1:0]            cfg_gain_p = hpid_pkg::GAIN_P_RST;
    logic [hpid_pkg::GAIN_WIDTH-1:0]            cfg_gain_i = hpid_pkg::GAIN_I_RST;
    logic [hpid_pkg::GAIN_WIDTH-1:0]            cfg_gain_d = hpid_pkg::GAIN_D_RST;
    logic [hpid_pkg::SPEED_WIDTH-1:0]           cfg_speed = hpid_pkg::SPEED_PCT_RST;
    logic signed [hpid_pkg::HEADING_WIDTH-1:0]  cfg_target = hpid_pkg::TARGET_RST;
    logic [hpid_pkg::BAND_WIDTH-1:0]            cfg_band = hpid_pkg::SETTLE_BAND_RST;
    logic [hpid_pkg::TICKS_WIDTH-1:0]           cfg_ticks = hpid_pkg::SETTLE_TICKS_RST;

    longint                                     integral_sum = 0;
    longint                                     prev_error = 0;
    int                                         band_count = 0;

    logic [hpid_pkg::HEADING_WIDTH-1:0]         heading_feed_q[$];
    drive_word_t                                drive_due_q[$];

    int                                         send_idle_pct = 35;
    int                                         recv_idle_pct = 88;
    int                                         cycles = 0;
    int                                         words_sent = 0;
    int                                         words_checked = 0;
    int                                         settle_count = 0;
    int                                         clamp_count = 0;
    int                                         mismatches = 0;

    heading_pid_with_clamp_and_settle dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic longint sat_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
        begin
            s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        return s;
    endfunction

    function automatic drive_word_t predict_drive(
        input logic signed [hpid_pkg::HEADING_WIDTH-1:0] heading);
        longint      err;
        longint      diff;
        longint      acc;
        longint      drive;
        longint      limit;
        longint      speed;
        longint      sgn;
        drive_word_t word;
        err = longint'(cfg_target) - longint'(heading);
        integral_sum = integral_sum + err;
        if (integral_sum > SUM_MAX)
        begin
            integral_sum = SUM_MAX;
        end
        if (integral_sum < SUM_MIN)
        begin
            integral_sum = SUM_MIN;
        end
        diff = err - prev_error;
        acc = longint'(cfg_gain_p) * err;
        acc = sat_add(acc, longint'(cfg_gain_i) * integral_sum);
        acc = sat_add(acc, longint'(cfg_gain_d) * diff);
        drive = acc / (longint'(1) << hpid_pkg::GAIN_FRAC_BITS);
        speed = (cfg_speed > hpid_pkg::SPEED_FULL) ? longint'(hpid_pkg::SPEED_FULL)
                                                   : longint'(cfg_speed);
        limit = (speed * VOLT_FULL) / longint'(hpid_pkg::SPEED_FULL);
        sgn = (err > 0) ? 1 : ((err < 0) ? -1 : 0);
        if ((drive < 0 ? -drive : drive) >= limit)
        begin
            drive = limit * sgn;
            clamp_count++;
        end
        if ((err < 0 ? -err : err) <= longint'(cfg_band))
        begin
            band_count++;
            if (band_count >= int'(cfg_ticks))
            begin
                integral_sum = 0;
                prev_error = 0;
                band_count = 0;
                word.settled = 1'b1;
                word.drive = '0;
                return word;
            end
        end
        else
        begin
            band_count = 0;
        end
        prev_error = err;
        word.settled = 1'b0;
        word.drive = drive[hpid_pkg::DRIVE_WIDTH-1:0];
        return word;
    endfunction

    function automatic logic [hpid_pkg::HEADING_WIDTH-1:0] clip_heading(input int v);
        if (v > HEAD_MAX)
        begin
            return HEAD_MAX[hpid_pkg::HEADING_WIDTH-1:0];
        end
        if (v < HEAD_MIN)
        begin
            return HEAD_MIN[hpid_pkg::HEADING_WIDTH-1:0];
        end
        return v[hpid_pkg::HEADING_WIDTH-1:0];
    endfunction

    function automatic logic [hpid_pkg::DATA_WIDTH-1:0] pad_junk(
        input logic [hpid_pkg::DATA_WIDTH-1:0] v,
        input int width);
        logic [hpid_pkg::DATA_WIDTH-1:0] keep;
        keep = (hpid_pkg::DATA_WIDTH'(1) << width) - 1;
        return (hpid_pkg::DATA_WIDTH'($urandom) & ~keep) | (v & keep);
    endfunction

    function automatic logic [hpid_pkg::DATA_WIDTH-1:0] pick_gain();
        case ($urandom_range(7))
            0: return 0;
            1: return 65535;
            2, 3: return $urandom_range(65535);
            default: return $urandom_range(1024);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx,
                             input logic [hpid_pkg::DATA_WIDTH-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            hpid_pkg::REG_GAIN_P:
                cfg_gain_p = value[hpid_pkg::GAIN_WIDTH-1:0];
            hpid_pkg::REG_GAIN_I:
                cfg_gain_i = value[hpid_pkg::GAIN_WIDTH-1:0];
            hpid_pkg::REG_GAIN_D:
                cfg_gain_d = value[hpid_pkg::GAIN_WIDTH-1:0];
            hpid_pkg::REG_SPEED_PCT:
                cfg_speed = value[hpid_pkg::SPEED_WIDTH-1:0];
            hpid_pkg::REG_TARGET_HEADING:
                cfg_target = value[hpid_pkg::HEADING_WIDTH-1:0];
            hpid_pkg::REG_SETTLE_BAND:
                cfg_band = value[hpid_pkg::BAND_WIDTH-1:0];
            hpid_pkg::REG_SETTLE_TICKS:
                cfg_ticks = value[hpid_pkg::TICKS_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (heading_feed_q.size() != 0 || s_tvalid || drive_due_q.size() != 0);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                drive_due_q.push_back(predict_drive(s_tdata[hpid_pkg::HEADING_WIDTH-1:0]));
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (heading_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= heading_feed_q.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready)
            begin
                words_checked++;
                if (m_tuser)
                begin
                    settle_count++;
                end
                if (drive_due_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, %s %0d settled %0b",
                             $time, "got drive", $signed(m_tdata[hpid_pkg::DRIVE_WIDTH-1:0]),
                             m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = drive_due_q.pop_front();
                    if (m_tdata !== {{(8*hpid_pkg::OUT_BYTES-hpid_pkg::DRIVE_WIDTH){1'b0}},
                                     want.drive})
                    begin
                        $display("%0t: drive mismatch, expected %0d (0x%h), got 0x%h",
                                 $time, $signed(want.drive), want.drive, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== want.settled)
                    begin
                        $display("%0t: settled mismatch, expected %0b, got %0b",
                                 $time, want.settled, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d result words outstanding",
                     cycles, drive_due_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int off;
        int base;
        int band;
        int batch_len;
        int round;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero error, both extremes, a reversal that pulls the
        // raw drive against the error sign, band edges, then a settle run.
        heading_feed_q = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0004,
                           16'hFFFC, 16'h0005, 16'hFFFB, 16'h0000, 16'h0000, 16'h0000,
                           16'h0000, 16'h0000, 16'h0000, 16'h0000};
        wait_drained();

        write_reg(hpid_pkg::REG_GAIN_P, 32'd65535);
        write_reg(hpid_pkg::REG_GAIN_I, 32'd65535);
        write_reg(hpid_pkg::REG_GAIN_D, 32'd65535);
        write_reg(hpid_pkg::REG_SPEED_PCT, 32'd127);
        write_reg(hpid_pkg::REG_TARGET_HEADING, 32'h0000_7FFF);
        write_reg(hpid_pkg::REG_SETTLE_BAND, 32'd255);
        write_reg(hpid_pkg::REG_SETTLE_TICKS, 32'd0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        heading_feed_q = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7F00, 16'h0000};
        wait_drained();

        write_reg(hpid_pkg::REG_SPEED_PCT, 32'd5);
        heading_feed_q = '{16'h0000, 16'h7FFF};
        wait_drained();

        // Wind the integral up in both directions.
        write_reg(hpid_pkg::REG_GAIN_P, 32'd0);
        write_reg(hpid_pkg::REG_GAIN_I, 32'd1);
        write_reg(hpid_pkg::REG_GAIN_D, 32'd0);
        write_reg(hpid_pkg::REG_SPEED_PCT, 32'd100);
        write_reg(hpid_pkg::REG_SETTLE_BAND, 32'd0);
        write_reg(hpid_pkg::REG_SETTLE_TICKS, 32'd1);
        repeat (WINDUP_WORDS) heading_feed_q.push_back(16'h8000);
        heading_feed_q.push_back(16'h7FFF);
        wait_drained();
        write_reg(hpid_pkg::REG_TARGET_HEADING, 32'hFFFF_8000);
        repeat (WINDUP_WORDS) heading_feed_q.push_back(16'h7FFF);
        wait_drained();

        for (round = 0; round < 30; round++)
        begin
            if (round < 10)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 88;
            end
            else if (round < 20)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            write_reg(hpid_pkg::REG_GAIN_P, pad_junk(pick_gain(), hpid_pkg::GAIN_WIDTH));
            write_reg(hpid_pkg::REG_GAIN_I, pad_junk(pick_gain(), hpid_pkg::GAIN_WIDTH));
            write_reg(hpid_pkg::REG_GAIN_D, pad_junk(pick_gain(), hpid_pkg::GAIN_WIDTH));
            case ($urandom_range(5))
                0: write_reg(hpid_pkg::REG_SPEED_PCT,
                             pad_junk(0, hpid_pkg::SPEED_WIDTH));
                1: write_reg(hpid_pkg::REG_SPEED_PCT,
                             pad_junk(127, hpid_pkg::SPEED_WIDTH));
                2: write_reg(hpid_pkg::REG_SPEED_PCT,
                             pad_junk($urandom_range(8), hpid_pkg::SPEED_WIDTH));
                default: write_reg(hpid_pkg::REG_SPEED_PCT,
                                   pad_junk($urandom_range(127), hpid_pkg::SPEED_WIDTH));
            endcase
            case ($urandom_range(5))
                0: write_reg(hpid_pkg::REG_TARGET_HEADING,
                             pad_junk(32'h8000, hpid_pkg::HEADING_WIDTH));
                1: write_reg(hpid_pkg::REG_TARGET_HEADING,
                             pad_junk(32'h7FFF, hpid_pkg::HEADING_WIDTH));
                default: write_reg(hpid_pkg::REG_TARGET_HEADING,
                                   pad_junk($urandom_range(65535), hpid_pkg::HEADING_WIDTH));
            endcase
            case ($urandom_range(4))
                0: write_reg(hpid_pkg::REG_SETTLE_BAND,
                             pad_junk(0, hpid_pkg::BAND_WIDTH));
                1: write_reg(hpid_pkg::REG_SETTLE_BAND,
                             pad_junk(255, hpid_pkg::BAND_WIDTH));
                default: write_reg(hpid_pkg::REG_SETTLE_BAND,
                                   pad_junk($urandom_range(20), hpid_pkg::BAND_WIDTH));
            endcase
            write_reg(hpid_pkg::REG_SETTLE_TICKS,
                      pad_junk($urandom_range(15), hpid_pkg::TICKS_WIDTH));

            // Mostly moves that close in on the target and settle, with
            // stretches of unrelated headings in between.
            batch_len = $urandom_range(25, 45);
            base = int'(cfg_target);
            band = int'(cfg_band);
            while (heading_feed_q.size() < batch_len)
            begin
                if ($urandom_range(9) < 7)
                begin
                    off = int'($urandom_range(65535)) - 32768;
                    repeat ($urandom_range(4, 14))
                    begin
                        heading_feed_q.push_back(clip_heading(base + off));
                        off = off * int'($urandom_range(2, 7)) / 10
                              + int'($urandom_range(4)) - 2;
                    end
                    repeat (int'(cfg_ticks) + 1 + $urandom_range(2))
                    begin
                        heading_feed_q.push_back(
                            clip_heading(base + int'($urandom_range(2 * band)) - band));
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        heading_feed_q.push_back(hpid_pkg::HEADING_WIDTH'($urandom));
                    end
                end
            end
            wait_drained();
        end

        $display("Sent %0d heading words and checked %0d result words; %0d settled, %0d clamped.",
                 words_sent, words_checked, settle_count, clamp_count);
        $display("Covered reset settings, register extremes, integral windup both ways %s",
                 "and 30 random rounds.");
        if (mismatches == 0 && drive_due_q.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hpid_pkg.sv
rtl/heading_pid_with_clamp_and_settle.sv
rtl/hpid_checker.sv
dv/tb.sv
